[design/dotq_pkg.sv]
// Shared types, constants and compare functions for the deadline-ordered timer queue.
// Used by the channel interfaces, the RAM wrapper users, the controller and the datapath.
package dotq_pkg;

	localparam int QUEUE_DEPTH = 16;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam int ADDR_W = $clog2(QUEUE_DEPTH);
	localparam int TERM_W = 32;
	localparam int ID_W = 8;
	localparam int OP_W = 2;
	localparam int PEND_W = 5;

	localparam logic [TERM_W-1:0] HALFWAY_RESET = 32'h8000_0000;

	typedef enum logic [OP_W-1:0] {
		OP_POLL   = 2'd0,
		OP_SCHED  = 2'd1,
		OP_CANCEL = 2'd2
	} opcode_t;

	typedef struct packed {
		logic [TERM_W-1:0] term;
		logic [ID_W-1:0]   comp;
		logic [ID_W-1:0]   serv;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef enum logic [13:0] {
		ST_IDLE     = 14'h0001,
		ST_DISPATCH = 14'h0002,
		ST_POLL_CHK = 14'h0004,
		ST_REM_RD   = 14'h0008,
		ST_REM_WR   = 14'h0010,
		ST_SCH_HEAD = 14'h0020,
		ST_SCH_WALK = 14'h0040,
		ST_SCH_CMP  = 14'h0080,
		ST_SCH_DEC  = 14'h0100,
		ST_INS_RD   = 14'h0200,
		ST_INS_WR   = 14'h0400,
		ST_CAN_RD   = 14'h0800,
		ST_CAN_CHK  = 14'h1000,
		ST_FINISH   = 14'h2000
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic latch;
		logic rd_idx;
		logic rd_idx_inc;
		logic rd_idx_dec;
		logic wr_idx_rdata;
		logic wr_new_pos;
		logic idx_inc;
		logic idx_dec;
		logic idx_load_count;
		logic cur_load_rdata;
		logic pos_load;
		logic pos_clear;
		logic cnt_inc;
		logic cnt_dec;
		logic set_fired;
		logic set_found;
		logic set_full;
		logic out_load;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		opcode_t op;
		logic    cnt_zero;
		logic    cnt_full;
		logic    idx_inc_lt_cnt;
		logic    idx_lt_cnt;
		logic    idx_gt_pos;
		logic    head_due;
		logic    new_after_rd;
		logic    match;
		logic    out_free;
	} status_t;

	// True when a new entry with term t belongs after an entry with term other.
	function automatic logic goes_after(input logic [TERM_W-1:0] t,
			input logic [TERM_W-1:0] other, input logic [TERM_W-1:0] half);
		return ((t < half) && (other > half)) || (t > other);
	endfunction

	// True when an entry with term t has expired at time now.
	function automatic logic is_due(input logic [TERM_W-1:0] t,
			input logic [TERM_W-1:0] now, input logic [TERM_W-1:0] half);
		return (t <= now) || ((t >= half) && (now < half));
	endfunction

endpackage

[design/dotq_req_if.sv]
// Request channel of the timer queue: valid/ready handshake with the item fields.
// Depends on dotq_pkg for the field widths.
interface dotq_req_if;
	logic                         valid;
	logic                         ready;
	logic [dotq_pkg::OP_W-1:0]    opcode;
	logic [dotq_pkg::TERM_W-1:0]  now_ms;
	logic [dotq_pkg::ID_W-1:0]    component_id;
	logic [dotq_pkg::ID_W-1:0]    service_id;
	logic [dotq_pkg::TERM_W-1:0]  delay_ms;

	modport source (output valid, opcode, now_ms, component_id, service_id, delay_ms,
		input ready);
	modport sink (input valid, opcode, now_ms, component_id, service_id, delay_ms,
		output ready);
endinterface

[design/dotq_rsp_if.sv]
// Response channel of the timer queue: valid/ready handshake with the result fields.
// Depends on dotq_pkg for the field widths.
interface dotq_rsp_if;
	logic                         valid;
	logic                         ready;
	logic                         fired;
	logic [dotq_pkg::ID_W-1:0]    fired_component;
	logic [dotq_pkg::ID_W-1:0]    fired_service;
	logic                         cancel_found;
	logic                         queue_full;
	logic [dotq_pkg::PEND_W-1:0]  pending_count;

	modport source (output valid, fired, fired_component, fired_service, cancel_found,
		queue_full, pending_count, input ready);
	modport sink (input valid, fired, fired_component, fired_service, cancel_found,
		queue_full, pending_count, output ready);
endinterface

[design/dotq_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module dotq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[design/dotq_ctrl.sv]
// Controller state machine of the timer queue: sequences RAM walks and shifts.
// Depends on dotq_pkg for the state, command and status types.
module dotq_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	input  dotq_pkg::status_t status,
	output dotq_pkg::cmd_t    cmd
);

	dotq_pkg::state_t state_q, state_d;

	assign req_ready = (state_q == dotq_pkg::ST_IDLE);

	always_comb begin
		cmd = '0;
		state_d = state_q;
		unique case (state_q)
			dotq_pkg::ST_IDLE: begin
				if (req_valid) begin
					cmd.latch = 1'b1;
					state_d = dotq_pkg::ST_DISPATCH;
				end
			end
			dotq_pkg::ST_DISPATCH: begin
				unique case (status.op)
					dotq_pkg::OP_POLL: begin
						if (status.cnt_zero) begin
							state_d = dotq_pkg::ST_FINISH;
						end else begin
							cmd.rd_idx = 1'b1;
							state_d = dotq_pkg::ST_POLL_CHK;
						end
					end
					dotq_pkg::OP_SCHED: begin
						if (status.cnt_full) begin
							cmd.set_full = 1'b1;
							state_d = dotq_pkg::ST_FINISH;
						end else if (status.cnt_zero) begin
							cmd.pos_clear = 1'b1;
							cmd.idx_load_count = 1'b1;
							state_d = dotq_pkg::ST_INS_RD;
						end else begin
							cmd.rd_idx = 1'b1;
							state_d = dotq_pkg::ST_SCH_HEAD;
						end
					end
					dotq_pkg::OP_CANCEL: begin
						state_d = dotq_pkg::ST_CAN_RD;
					end
					default: begin
						state_d = dotq_pkg::ST_FINISH;
					end
				endcase
			end
			dotq_pkg::ST_POLL_CHK: begin
				if (status.head_due) begin
					cmd.set_fired = 1'b1;
					state_d = dotq_pkg::ST_REM_RD;
				end else begin
					state_d = dotq_pkg::ST_FINISH;
				end
			end
			// Removal closes the gap at idx by moving each later entry down one slot.
			dotq_pkg::ST_REM_RD: begin
				if (status.idx_inc_lt_cnt) begin
					cmd.rd_idx_inc = 1'b1;
					state_d = dotq_pkg::ST_REM_WR;
				end else begin
					cmd.cnt_dec = 1'b1;
					state_d = dotq_pkg::ST_FINISH;
				end
			end
			dotq_pkg::ST_REM_WR: begin
				cmd.wr_idx_rdata = 1'b1;
				cmd.idx_inc = 1'b1;
				state_d = dotq_pkg::ST_REM_RD;
			end
			dotq_pkg::ST_SCH_HEAD: begin
				cmd.cur_load_rdata = 1'b1;
				state_d = dotq_pkg::ST_SCH_WALK;
			end
			dotq_pkg::ST_SCH_WALK: begin
				if (status.idx_inc_lt_cnt) begin
					cmd.rd_idx_inc = 1'b1;
					state_d = dotq_pkg::ST_SCH_CMP;
				end else begin
					state_d = dotq_pkg::ST_SCH_DEC;
				end
			end
			dotq_pkg::ST_SCH_CMP: begin
				if (status.new_after_rd) begin
					cmd.idx_inc = 1'b1;
					cmd.cur_load_rdata = 1'b1;
					state_d = dotq_pkg::ST_SCH_WALK;
				end else begin
					state_d = dotq_pkg::ST_SCH_DEC;
				end
			end
			dotq_pkg::ST_SCH_DEC: begin
				cmd.pos_load = 1'b1;
				cmd.idx_load_count = 1'b1;
				state_d = dotq_pkg::ST_INS_RD;
			end
			// Insertion opens a slot at pos by moving entries up, starting at the tail.
			dotq_pkg::ST_INS_RD: begin
				if (status.idx_gt_pos) begin
					cmd.rd_idx_dec = 1'b1;
					state_d = dotq_pkg::ST_INS_WR;
				end else begin
					cmd.wr_new_pos = 1'b1;
					cmd.cnt_inc = 1'b1;
					state_d = dotq_pkg::ST_FINISH;
				end
			end
			dotq_pkg::ST_INS_WR: begin
				cmd.wr_idx_rdata = 1'b1;
				cmd.idx_dec = 1'b1;
				state_d = dotq_pkg::ST_INS_RD;
			end
			dotq_pkg::ST_CAN_RD: begin
				if (status.idx_lt_cnt) begin
					cmd.rd_idx = 1'b1;
					state_d = dotq_pkg::ST_CAN_CHK;
				end else begin
					state_d = dotq_pkg::ST_FINISH;
				end
			end
			dotq_pkg::ST_CAN_CHK: begin
				if (status.match) begin
					cmd.set_found = 1'b1;
					state_d = dotq_pkg::ST_REM_RD;
				end else begin
					cmd.idx_inc = 1'b1;
					state_d = dotq_pkg::ST_CAN_RD;
				end
			end
			dotq_pkg::ST_FINISH: begin
				if (status.out_free) begin
					cmd.out_load = 1'b1;
					state_d = dotq_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = dotq_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dotq_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// A finished result waits in place until the output register can take it.
	a_finish_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == dotq_pkg::ST_FINISH) && !status.out_free
		|=> state_q == dotq_pkg::ST_FINISH)
		else $error("result lost while output register busy");

endmodule

[design/dotq_datapath.sv]
// Datapath of the timer queue: entry RAM, index and count registers, compares, result register.
// Depends on dotq_pkg and dotq_ram.
module dotq_datapath (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [dotq_pkg::TERM_W-1:0]  cfg_wdata,
	input  logic [dotq_pkg::OP_W-1:0]    opcode,
	input  logic [dotq_pkg::TERM_W-1:0]  now_ms,
	input  logic [dotq_pkg::ID_W-1:0]    component_id,
	input  logic [dotq_pkg::ID_W-1:0]    service_id,
	input  logic [dotq_pkg::TERM_W-1:0]  delay_ms,
	input  logic                         rsp_ready,
	output logic                         rsp_valid,
	output logic                         fired,
	output logic [dotq_pkg::ID_W-1:0]    fired_component,
	output logic [dotq_pkg::ID_W-1:0]    fired_service,
	output logic                         cancel_found,
	output logic                         queue_full,
	output logic [dotq_pkg::PEND_W-1:0]  pending_count,
	input  dotq_pkg::cmd_t               cmd,
	output dotq_pkg::status_t            status
);

	logic [dotq_pkg::TERM_W-1:0] half_q;
	dotq_pkg::opcode_t           op_q;
	logic [dotq_pkg::TERM_W-1:0] now_q;
	logic [dotq_pkg::TERM_W-1:0] term_q;
	logic [dotq_pkg::ID_W-1:0]   comp_q;
	logic [dotq_pkg::ID_W-1:0]   serv_q;
	logic [dotq_pkg::TERM_W-1:0] cur_term_q;
	logic [dotq_pkg::CNT_W-1:0]  idx_q;
	logic [dotq_pkg::CNT_W-1:0]  pos_q;
	logic [dotq_pkg::CNT_W-1:0]  count_q;
	logic                        fired_q;
	logic [dotq_pkg::ID_W-1:0]   fc_q;
	logic [dotq_pkg::ID_W-1:0]   fs_q;
	logic                        found_q;
	logic                        full_q;

	logic [dotq_pkg::CNT_W-1:0]  idx_inc;
	logic [dotq_pkg::CNT_W-1:0]  idx_dec;
	logic [dotq_pkg::TERM_W-1:0] delay_eff;
	logic                        ram_we;
	logic [dotq_pkg::ADDR_W-1:0] ram_waddr;
	logic [dotq_pkg::ENTRY_W-1:0] ram_wdata;
	logic                        ram_re;
	logic [dotq_pkg::ADDR_W-1:0] ram_raddr;
	logic [dotq_pkg::ENTRY_W-1:0] ram_rdata;
	dotq_pkg::entry_t            rd_entry;
	dotq_pkg::entry_t            new_entry;

	assign idx_inc = idx_q + dotq_pkg::CNT_W'(1);
	assign idx_dec = idx_q - dotq_pkg::CNT_W'(1);
	assign delay_eff = (delay_ms == '0) ? dotq_pkg::TERM_W'(1) : delay_ms;
	assign rd_entry = dotq_pkg::entry_t'(ram_rdata);
	assign new_entry = '{term: term_q, comp: comp_q, serv: serv_q};

	// Entry store: one read and one write per cycle.
	assign ram_re = cmd.rd_idx || cmd.rd_idx_inc || cmd.rd_idx_dec;
	always_comb begin
		if (cmd.rd_idx_inc) begin
			ram_raddr = idx_inc[dotq_pkg::ADDR_W-1:0];
		end else if (cmd.rd_idx_dec) begin
			ram_raddr = idx_dec[dotq_pkg::ADDR_W-1:0];
		end else begin
			ram_raddr = idx_q[dotq_pkg::ADDR_W-1:0];
		end
	end

	assign ram_we = cmd.wr_idx_rdata || cmd.wr_new_pos;
	assign ram_waddr = cmd.wr_new_pos ? pos_q[dotq_pkg::ADDR_W-1:0]
		: idx_q[dotq_pkg::ADDR_W-1:0];
	assign ram_wdata = cmd.wr_new_pos ? new_entry : ram_rdata;

	dotq_ram #(
		.WIDTH(dotq_pkg::ENTRY_W),
		.DEPTH(dotq_pkg::QUEUE_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_q <= dotq_pkg::HALFWAY_RESET;
		end else if (cfg_we) begin
			half_q <= cfg_wdata;
		end
	end

	// Item fields; the new term wraps modulo 2^32.
	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			op_q <= dotq_pkg::opcode_t'(opcode);
			now_q <= now_ms;
			term_q <= now_ms + delay_eff;
			comp_q <= component_id;
			serv_q <= service_id;
		end
		if (cmd.cur_load_rdata) begin
			cur_term_q <= rd_entry.term;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			pos_q <= '0;
			count_q <= '0;
		end else begin
			if (cmd.latch) begin
				idx_q <= '0;
			end else if (cmd.idx_inc) begin
				idx_q <= idx_inc;
			end else if (cmd.idx_dec) begin
				idx_q <= idx_dec;
			end else if (cmd.idx_load_count) begin
				idx_q <= count_q;
			end

			if (cmd.pos_clear) begin
				pos_q <= '0;
			end else if (cmd.pos_load) begin
				pos_q <= dotq_pkg::goes_after(term_q, cur_term_q, half_q) ? idx_inc : '0;
			end

			if (cmd.cnt_inc) begin
				count_q <= count_q + dotq_pkg::CNT_W'(1);
			end else if (cmd.cnt_dec) begin
				count_q <= count_q - dotq_pkg::CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fired_q <= 1'b0;
			fc_q <= '0;
			fs_q <= '0;
			found_q <= 1'b0;
			full_q <= 1'b0;
		end else if (cmd.latch) begin
			fired_q <= 1'b0;
			fc_q <= '0;
			fs_q <= '0;
			found_q <= 1'b0;
			full_q <= 1'b0;
		end else begin
			if (cmd.set_fired) begin
				fired_q <= 1'b1;
				fc_q <= rd_entry.comp;
				fs_q <= rd_entry.serv;
			end
			if (cmd.set_found) begin
				found_q <= 1'b1;
			end
			if (cmd.set_full) begin
				full_q <= 1'b1;
			end
		end
	end

	// Output register: a finished result waits here while the next item is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid <= 1'b0;
		end else if (cmd.out_load) begin
			rsp_valid <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			fired <= fired_q;
			fired_component <= fc_q;
			fired_service <= fs_q;
			cancel_found <= found_q;
			queue_full <= full_q;
			pending_count <= dotq_pkg::PEND_W'(count_q);
		end
	end

	always_comb begin
		status.op = op_q;
		status.cnt_zero = (count_q == '0);
		status.cnt_full = (count_q >= dotq_pkg::CNT_W'(dotq_pkg::QUEUE_DEPTH));
		status.idx_inc_lt_cnt = (idx_inc < count_q);
		status.idx_lt_cnt = (idx_q < count_q);
		status.idx_gt_pos = (idx_q > pos_q);
		status.head_due = dotq_pkg::is_due(rd_entry.term, now_q, half_q);
		status.new_after_rd = dotq_pkg::goes_after(term_q, rd_entry.term, half_q);
		status.match = (rd_entry.comp == comp_q) && (rd_entry.serv == serv_q);
		status.out_free = !rsp_valid || rsp_ready;
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= dotq_pkg::CNT_W'(dotq_pkg::QUEUE_DEPTH))
		else $error("entry count above queue depth");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q != $past(count_q)) |->
		((count_q == $past(count_q) + dotq_pkg::CNT_W'(1))
		|| (count_q == $past(count_q) - dotq_pkg::CNT_W'(1))))
		else $error("entry count moved by more than one");

	a_one_flag: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> ($countones({fired, cancel_found, queue_full}) <= 1))
		else $error("more than one result flag set");

endmodule

[design/deadline_ordered_timer_queue.sv]
// Top level of the deadline-ordered timer queue: controller plus datapath.
// Depends on dotq_pkg, dotq_req_if, dotq_rsp_if, dotq_ctrl and dotq_datapath.
//
// The queue holds up to QUEUE_DEPTH timers sorted by term in a single RAM with a
// registered read, so every entry visited or moved is first read and then used or
// written back. A poll on an empty table finishes without a read; otherwise it reads the
// head and, when the head is due, fires it and moves every later entry down one slot. A
// schedule on a full table reports queue_full; otherwise it walks past the entries that
// the new term goes after, moves the later entries up from the tail to open the slot
// and writes the new entry there. A cancel scans for a matching component and service
// and, when found, moves every later entry down; an unused opcode changes nothing. A
// result waits while the output register stays occupied. One item is worked at a time;
// the result sits in an output register, so the next request transfer is taken while it
// waits. The halfway threshold must be written through cfg_we/cfg_wdata only while the
// block is idle; the block itself does not enforce this.
module deadline_ordered_timer_queue (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [dotq_pkg::TERM_W-1:0]  cfg_wdata,
	dotq_req_if.sink                     req,
	dotq_rsp_if.source                   rsp
);

	dotq_pkg::cmd_t    cmd;
	dotq_pkg::status_t status;

	dotq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.status    (status),
		.cmd       (cmd)
	);

	dotq_datapath u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_wdata       (cfg_wdata),
		.opcode          (req.opcode),
		.now_ms          (req.now_ms),
		.component_id    (req.component_id),
		.service_id      (req.service_id),
		.delay_ms        (req.delay_ms),
		.rsp_ready       (rsp.ready),
		.rsp_valid       (rsp.valid),
		.fired           (rsp.fired),
		.fired_component (rsp.fired_component),
		.fired_service   (rsp.fired_service),
		.cancel_found    (rsp.cancel_found),
		.queue_full      (rsp.queue_full),
		.pending_count   (rsp.pending_count),
		.cmd             (cmd),
		.status          (status)
	);

endmodule
